### sv/olist_pkg.sv
// Package for the ordered list engine: command and status codes and the
// control word that the top level broadcasts to every list cell.
// No dependencies.
package olist_pkg;

  // Command codes carried in the func field of an input word.
  typedef enum logic [2:0] {
    FN_INS_FRONT = 3'd0,
    FN_INS_BACK  = 3'd1,
    FN_INS_POS   = 3'd2,
    FN_DEL_FRONT = 3'd3,
    FN_DEL_BACK  = 3'd4,
    FN_DEL_POS   = 3'd5,
    FN_COUNT     = 3'd6,
    FN_REVERSE   = 3'd7
  } func_e;

  // Status codes returned with every result word.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  // What every cell does with its element in the current cycle.
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2
  } cell_op_e;

  // Control word shared by the whole row of cells.
  typedef struct packed {
    cell_op_e op;        // shift action at the selected index
    logic     match_en;  // capture the compare result of this cell
  } cell_ctrl_t;

  // Field widths of the stream words.
  localparam int unsigned ValueW = 32;
  localparam int unsigned PosW   = 7;
  localparam int unsigned LenW   = 7;

endpackage

### sv/olist_cell.sv
// One cell of the list row: holds a single element, shifts toward either
// neighbor on insert or delete, and compares its element for the count.
// Depends on olist_pkg.
module olist_cell
  import olist_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IDX   = 0
) (
  input  logic                         clk_i,
  input  cell_ctrl_t                   ctrl_i,
  input  logic [$clog2(DEPTH)-1:0]     idx_i,
  input  logic [ValueW-1:0]            value_i,
  input  logic [$clog2(DEPTH+1)-1:0]   count_i,
  input  logic [ValueW-1:0]            left_i,
  input  logic [ValueW-1:0]            right_i,
  output logic [ValueW-1:0]            data_o,
  output logic [ValueW-1:0]            sel_data_o,
  output logic                         match_o
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH+1);
  localparam logic [IW-1:0] IdxI = IW'(IDX);
  localparam logic [CW-1:0] IdxC = CW'(IDX);

  logic [ValueW-1:0] data_q, data_d;
  logic              match_q, match_d;

  // Next element: keep, take the new value, or take a neighbor's element.
  always_comb begin
    data_d = data_q;
    case (ctrl_i.op)
      CELL_INS: begin
        if (IdxI == idx_i) begin
          data_d = value_i;
        end else if (IdxI > idx_i) begin
          data_d = left_i;
        end
      end
      CELL_DEL: begin
        if (IdxI >= idx_i) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  // Only cells inside the list count toward a match.
  assign match_d = (data_q == value_i) && (IdxC < count_i);

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    if (ctrl_i.match_en) begin
      match_q <= match_d;
    end
  end

  assign data_o     = data_q;
  assign sel_data_o = (IdxI == idx_i) ? data_q : '0;
  assign match_o    = match_q;

endmodule

### sv/ordered_list_engine_unit.sv
// Ordered list engine: a bounded list of up to DEPTH signed 32-bit values
// held in a row of cells, with insert, delete, count and reverse commands.
// Depends on olist_pkg and olist_cell.

// Each accepted command word is handled in two steps: in the first the cells
// compare their elements against the value and the command is latched, in
// the second the match bits are summed, every cell shifts in parallel and
// the result word is written to the output register. A new command is
// taken only once the previous one has left the execute cycle, so no new
// command is taken while one is in flight; a held result stalls the
// execute cycle. Reverse costs no data movement: a direction bit flips and
// later positions are mapped through it. Cell contents are not cleared at
// reset; only elements below the length are ever read.
module ordered_list_engine_unit
  import olist_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // func[2:0], value[34:3], position[41:35]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o    // status[1:0], removed_value[33:2],
                                        // match_count[40:34], length[47:41]
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH+1);
  localparam logic [7:0]  Depth8 = 8'(DEPTH);

  // Command register and control state.
  logic              busy_q;
  logic              rev_q, rev_d;
  logic [CW-1:0]     count_q, count_d;
  func_e             func_q;
  logic [ValueW-1:0] value_q;
  logic [PosW-1:0]   pos_q;
  logic              m_valid_q;
  logic [47:0]       m_data_q;

  logic       accept;
  logic       exec;
  cell_ctrl_t ctrl;
  logic [IW-1:0] idx;
  logic [ValueW-1:0] cmp_value;

  // Row wiring.
  logic [ValueW-1:0] cell_data [DEPTH];
  logic [ValueW-1:0] cell_sel  [DEPTH];
  logic [DEPTH-1:0]  cell_match;

  // Execute results.
  status_e           status;
  logic [ValueW-1:0] removed;
  logic [LenW-1:0]   match_cnt;
  logic [ValueW-1:0] sel_or;
  logic [LenW-1:0]   pop;
  logic [7:0]        cnt8, pos8, lk8, pk8;
  logic              do_ins, do_del;

  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = !busy_q;
  assign exec            = busy_q && (!m_valid_q || m_axis_tready_i);

  // While idle the cells compare against the incoming value.
  assign cmp_value = busy_q ? value_q : s_axis_tdata_i[34:3];

  // Sum of the captured match bits and the element at the selected index.
  always_comb begin
    pop    = '0;
    sel_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      pop    = pop + LenW'(cell_match[i]);
      sel_or = sel_or | cell_sel[i];
    end
  end

  // Command decode: status, logical index and its physical mapping.
  always_comb begin
    cnt8      = 8'(count_q);
    pos8      = {1'b0, pos_q};
    lk8       = '0;
    do_ins    = 1'b0;
    do_del    = 1'b0;
    status    = ST_OK;
    match_cnt = '0;
    rev_d     = rev_q;
    case (func_q)
      FN_INS_FRONT, FN_INS_BACK: begin
        if (cnt8 >= Depth8) begin
          status = ST_FULL;
        end else begin
          do_ins = 1'b1;
          lk8    = (func_q == FN_INS_FRONT) ? 8'd0 : cnt8;
        end
      end
      FN_INS_POS: begin
        if (cnt8 >= Depth8) begin
          status = ST_FULL;
        end else if (pos8 == 8'd0 || pos8 > cnt8 + 8'd1) begin
          status = ST_RANGE;
        end else begin
          do_ins = 1'b1;
          lk8    = pos8 - 8'd1;
        end
      end
      FN_DEL_FRONT, FN_DEL_BACK: begin
        if (cnt8 == 8'd0) begin
          status = ST_EMPTY;
        end else begin
          do_del = 1'b1;
          lk8    = (func_q == FN_DEL_FRONT) ? 8'd0 : cnt8 - 8'd1;
        end
      end
      FN_DEL_POS: begin
        if (cnt8 == 8'd0) begin
          status = ST_EMPTY;
        end else if (pos8 == 8'd0 || pos8 > cnt8) begin
          status = ST_RANGE;
        end else begin
          do_del = 1'b1;
          lk8    = pos8 - 8'd1;
        end
      end
      FN_COUNT: begin
        if (cnt8 == 8'd0) begin
          status = ST_EMPTY;
        end else begin
          match_cnt = pop;
        end
      end
      FN_REVERSE: rev_d = !rev_q;
      default: status = ST_OK;
    endcase

    // A reversed list is stored back to front.
    if (!rev_q) begin
      pk8 = lk8;
    end else if (do_ins) begin
      pk8 = cnt8 - lk8;
    end else begin
      pk8 = cnt8 - 8'd1 - lk8;
    end
    idx = pk8[IW-1:0];
  end

  assign removed = do_del ? sel_or : '0;

  // Length after the command.
  always_comb begin
    count_d = count_q;
    if (do_ins) begin
      count_d = count_q + CW'(1);
    end else if (do_del) begin
      count_d = count_q - CW'(1);
    end
  end

  // Broadcast control for the row.
  always_comb begin
    ctrl.match_en = accept;
    ctrl.op       = CELL_HOLD;
    if (exec && do_ins) begin
      ctrl.op = CELL_INS;
    end else if (exec && do_del) begin
      ctrl.op = CELL_DEL;
    end
  end

  // Row of cells, each fed by its neighbors; the ends see value_q and zero.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [ValueW-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = value_q;
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
    end
    if (g == DEPTH-1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
    end
    olist_cell #(
      .DEPTH (DEPTH),
      .IDX   (g)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .idx_i      (idx),
      .value_i    (cmp_value),
      .count_i    (count_q),
      .left_i     (left_w),
      .right_i    (right_w),
      .data_o     (cell_data[g]),
      .sel_data_o (cell_sel[g]),
      .match_o    (cell_match[g])
    );
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      rev_q     <= 1'b0;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (exec) begin
        busy_q <= 1'b0;
      end
      if (exec) begin
        rev_q     <= rev_d;
        count_q   <= count_d;
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Command and result payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q  <= func_e'(s_axis_tdata_i[2:0]);
      value_q <= s_axis_tdata_i[34:3];
      pos_q   <= s_axis_tdata_i[41:35];
    end
    if (exec) begin
      m_data_q <= {LenW'(count_d), match_cnt, removed, status};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

### tb/list_checker.sv
`timescale 1ns / 100ps
// Checker for the ordered list engine: watches both stream channels, keeps
// its own copy of the list and compares every result word it sees.
// Depends on olist_pkg.
module list_checker
  import olist_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [47:0] s_data_i,   // func[2:0], value[34:3], position[41:35]
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [47:0] m_data_i,   // status[1:0], removed_value[33:2],
                                  // match_count[40:34], length[47:41]
  output int          errors_o,
  output int          pending_o,
  output int          checked_o,
  output int          full_seen_o
);

  typedef struct {
    func_e         func;
    logic [31:0]   value;
    logic [PosW-1:0] position;
  } list_cmd_t;

  typedef struct {
    status_e       status;
    logic [31:0]   removed;
    logic [6:0]    match_cnt;
    logic [LenW-1:0] length;
  } list_reply_t;

  // Model of the list contents, element 0 at the front.
  logic [31:0] list_elems[$];
  // Replies still owed by the block, oldest first.
  list_reply_t owed_replies[$];

  // Apply one command to the list model and return the reply it causes.
  function automatic list_reply_t apply_command(list_cmd_t c);
    list_reply_t r;
    int          n;
    logic [31:0] tmp;
    r.status    = ST_OK;
    r.removed   = '0;
    r.match_cnt = '0;
    n = list_elems.size();
    case (c.func)
      FN_INS_FRONT, FN_INS_BACK: begin
        if (n >= DEPTH) r.status = ST_FULL;
        else if (c.func == FN_INS_FRONT) list_elems.push_front(c.value);
        else list_elems.push_back(c.value);
      end
      FN_INS_POS: begin
        // The full check wins over the position check.
        if (n >= DEPTH) r.status = ST_FULL;
        else if (c.position < 1 || c.position > n + 1) r.status = ST_RANGE;
        else list_elems.insert(c.position - 1, c.value);
      end
      FN_DEL_FRONT, FN_DEL_BACK: begin
        if (n == 0) r.status = ST_EMPTY;
        else if (c.func == FN_DEL_FRONT) r.removed = list_elems.pop_front();
        else r.removed = list_elems.pop_back();
      end
      FN_DEL_POS: begin
        if (n == 0) r.status = ST_EMPTY;
        else if (c.position < 1 || c.position > n) r.status = ST_RANGE;
        else begin
          r.removed = list_elems[c.position - 1];
          list_elems.delete(c.position - 1);
        end
      end
      FN_COUNT: begin
        if (n == 0) r.status = ST_EMPTY;
        else begin
          for (int i = 0; i < n; i++) begin
            if (list_elems[i] == c.value) r.match_cnt++;
          end
        end
      end
      default: begin
        for (int i = 0; i < n / 2; i++) begin
          tmp = list_elems[i];
          list_elems[i] = list_elems[n - 1 - i];
          list_elems[n - 1 - i] = tmp;
        end
      end
    endcase
    r.length = LenW'(list_elems.size());
    return r;
  endfunction

  // Compare results first: a result can never belong to a command taken
  // at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    list_cmd_t   cmd;
    list_reply_t want;
    list_reply_t got;
    int          errs;
    errs = 0;
    if (!rst_ni) begin
      list_elems.delete();
      owed_replies.delete();
      errors_o    <= 0;
      pending_o   <= 0;
      checked_o   <= 0;
      full_seen_o <= 0;
    end else begin
      if (m_valid_i && m_ready_i) begin
        got.status    = status_e'(m_data_i[1:0]);
        got.removed   = m_data_i[33:2];
        got.match_cnt = m_data_i[40:34];
        got.length    = m_data_i[47:41];
        if (owed_replies.size() == 0) begin
          $error("result word with no command waiting: %h", m_data_i);
          errs++;
        end else begin
          want = owed_replies.pop_front();
          checked_o <= checked_o + 1;
          if (want.status == ST_FULL) full_seen_o <= full_seen_o + 1;
          if (got.status != want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            errs++;
          end
          if (got.removed != want.removed) begin
            $error("removed_value: expected %0d, actual %0d",
                   $signed(want.removed), $signed(got.removed));
            errs++;
          end
          if (got.match_cnt != want.match_cnt) begin
            $error("match_count: expected %0d, actual %0d", want.match_cnt,
                   got.match_cnt);
            errs++;
          end
          if (got.length != want.length) begin
            $error("length: expected %0d, actual %0d", want.length, got.length);
            errs++;
          end
        end
      end
      if (s_valid_i && s_ready_i) begin
        cmd.func     = func_e'(s_data_i[2:0]);
        cmd.value    = s_data_i[34:3];
        cmd.position = s_data_i[41:35];
        owed_replies.push_back(apply_command(cmd));
      end
      errors_o  <= errors_o + errs;
      pending_o <= owed_replies.size();
    end
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// Top of the ordered list engine testbench: clock, reset, command stimulus
// and result back-pressure. Depends on olist_pkg, the engine and list_checker.
module testbench;
  import olist_pkg::*;

  localparam int unsigned DEPTH      = 16;
  localparam int          CYCLE_CAP  = 400000;
  localparam int          RAND_ITEMS = 880;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;   // func[2:0], value[34:3], position[41:35]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // status[1:0], removed_value[33:2],
                               // match_count[40:34], length[47:41]

  int   errors;
  int   pending;
  int   checked;
  int   full_seen;
  int   sent;
  int   cycles;
  logic quiet;
  logic stall_req;

  ordered_list_engine_unit #(.DEPTH(DEPTH)) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  list_checker #(.DEPTH(DEPTH)) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_i   (s_axis_tready),
    .s_data_i    (s_axis_tdata),
    .m_valid_i   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_i    (m_axis_tdata),
    .errors_o    (errors),
    .pending_o   (pending),
    .checked_o   (checked),
    .full_seen_o (full_seen)
  );

  // Clock with a 10 ns period.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit.
  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Offer one command word, after an optional idle burst, and wait until the
  // engine takes it.
  task automatic send_cmd(func_e f, logic [31:0] v, logic [PosW-1:0] p);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, p, v, f};
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
  endtask

  // Result side: ready stretches and stall bursts, one long hold-off on
  // request, and steady readiness once the run goes quiet.
  initial begin
    logic stall_done;
    stall_done    = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge clk_i);
    wait (rst_ni === 1'b1);
    forever begin
      if (stall_req && !stall_done) begin
        stall_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (80) @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    int          k;
    int          roll;
    logic        fill;
    func_e       f;
    logic [31:0] v;
    logic [6:0]  p;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    quiet         = 1'b0;
    stall_req     = 1'b0;
    sent          = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty list: every delete, count and reverse, bad insert positions.
    send_cmd(FN_DEL_FRONT, 32'd0, 7'd0);
    send_cmd(FN_DEL_BACK, 32'd0, 7'd0);
    send_cmd(FN_DEL_POS, 32'd0, 7'd5);
    send_cmd(FN_COUNT, 32'd0, 7'd0);
    send_cmd(FN_REVERSE, 32'd0, 7'd0);
    send_cmd(FN_INS_POS, 32'd1, 7'd0);
    send_cmd(FN_INS_POS, 32'd1, 7'd2);
    // One element: reverse it, then delete it by position.
    send_cmd(FN_INS_POS, 32'h8000_0000, 7'd1);
    send_cmd(FN_REVERSE, 32'd0, 7'd0);
    send_cmd(FN_DEL_POS, 32'd0, 7'd1);
    // A few elements with the extreme values, append through length+1.
    send_cmd(FN_INS_BACK, 32'h7fff_ffff, 7'd127);
    send_cmd(FN_INS_FRONT, 32'hffff_ffff, 7'd64);
    send_cmd(FN_INS_POS, 32'd0, 7'd3);
    send_cmd(FN_INS_POS, 32'hffff_ffff, 7'd5);
    // The last element must be counted too.
    send_cmd(FN_COUNT, 32'd0, 7'd0);
    send_cmd(FN_COUNT, 32'hffff_ffff, 7'd0);
    send_cmd(FN_REVERSE, 32'd0, 7'd0);
    // Positional deletes at both ends, then out of range.
    send_cmd(FN_DEL_POS, 32'd0, 7'd3);
    send_cmd(FN_DEL_POS, 32'd0, 7'd1);
    send_cmd(FN_DEL_POS, 32'd0, 7'd0);
    send_cmd(FN_DEL_POS, 32'd0, 7'd64);
    send_cmd(FN_DEL_BACK, 32'd0, 7'd0);
    send_cmd(FN_DEL_FRONT, 32'd0, 7'd0);

    // Random part: alternating fill and drain phases so the list swings
    // between empty and full; values often from a small pool so counts hit.
    for (k = 0; k < RAND_ITEMS; k++) begin
      if (k == 300) stall_req <= 1'b1;
      if (k == RAND_ITEMS - 120) quiet <= 1'b1;
      fill = ((k / 50) % 2) == 0;
      roll = $urandom_range(0, 9);
      if (roll < 6) f = fill ? func_e'($urandom_range(0, 2)) : func_e'($urandom_range(3, 5));
      else f = func_e'($urandom_range(0, 7));
      roll = $urandom_range(0, 9);
      if (roll < 4) v = $urandom_range(0, 4) - 2;
      else if (roll == 4) begin
        case ($urandom_range(0, 3))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          2: v = 32'h0000_0000;
          default: v = 32'hffff_ffff;
        endcase
      end else v = $urandom;
      if ($urandom_range(0, 4) == 0) p = 7'($urandom_range(0, 64));
      else p = 7'($urandom_range(0, DEPTH + 1));
      send_cmd(f, v, p);
    end
    s_axis_tvalid <= 1'b0;

    // Drain and let the pipeline settle.
    @(posedge clk_i);
    wait (pending == 0);
    repeat (20) @(posedge clk_i);
    $display("summary: %0d commands sent, %0d results checked, %0d inserts refused as full",
             sent, checked, full_seen);
    $display("summary: list swung between empty and %0d entries under random stalls",
             DEPTH);
    if (errors == 0 && checked == sent) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
